/* rtl/core/spq_pkg.sv */
// shared types and constants of the sorted priority queue
package spq_pkg;

    localparam int DEPTH  = 64;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int OCC_W  = 7;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

/* rtl/core/spq_in_if.sv */
// request channel: command, data word and priority
interface spq_in_if
    import spq_pkg::*;
;
    logic                      valid;
    logic                      ready;
    t_cmd                      cmd;
    logic signed [DATA_W-1:0]  item_data;
    logic signed [DATA_W-1:0]  item_priority;

    modport source (output valid, output cmd, output item_data, output item_priority,
                    input ready);
    modport sink   (input valid, input cmd, input item_data, input item_priority,
                    output ready);
endinterface

/* rtl/core/spq_out_if.sv */
// result channel: status, removed entry and occupancy
interface spq_out_if
    import spq_pkg::*;
;
    logic                      valid;
    logic                      ready;
    t_status                   status;
    logic signed [DATA_W-1:0]  out_data;
    logic signed [DATA_W-1:0]  out_priority;
    logic [OCC_W-1:0]          occupancy;

    modport source (output valid, output status, output out_data, output out_priority,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input out_data, input out_priority,
                    input occupancy, output ready);
endinterface

/* rtl/core/sorted_priority_queue_core.sv */
// Sorted priority queue of DEPTH entries held in a chain of compare-and-shift cells.
// On every accepted transfer all cells compare the new priority against their own in
// parallel, and the chain shifts back on an insert or forward on a remove at the edge
// that takes the request, so a new request can be taken every cycle as long as the
// result register is free or drained in the same cycle. The result appears on the
// output channel in the cycle after the request transfer. The head of the queue is cell
// zero; among equal priorities the oldest entry sits nearer the head. An insert into a
// full queue is refused with ST_FULL, a remove from an empty queue answers ST_EMPTY;
// both leave the queue untouched. No clearing pass runs after reset: the entry count
// alone marks which cells hold entries.
module sorted_priority_queue_core
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_in_if.sink    i_req,
    spq_out_if.source o_rsp
);
    // entry count and result register
    logic [CNT_W-1:0]         r_count, n_count;
    logic                     r_out_valid, n_out_valid;
    t_status                  r_status, n_status;
    logic signed [DATA_W-1:0] r_out_data, n_out_data;
    logic signed [DATA_W-1:0] r_out_prio, n_out_prio;

    logic      w_accept;
    logic      w_full;
    logic      w_empty;
    t_cell_ctl w_ctl;

    // per-cell chain signals
    logic                     w_occ  [DEPTH];
    logic                     w_gt   [DEPTH];
    logic signed [DATA_W-1:0] w_data [DEPTH];
    logic signed [DATA_W-1:0] w_prio [DEPTH];

    // take a request when the result slot is free or being drained this cycle
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    assign w_ctl.ins = w_accept && (i_req.cmd == CMD_INSERT) && !w_full;
    assign w_ctl.rem = w_accept && (i_req.cmd == CMD_REMOVE) && !w_empty;

    // chain of cells, head at index zero
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                     w_prev_gt;
        logic signed [DATA_W-1:0] w_prev_data;
        logic signed [DATA_W-1:0] w_prev_prio;
        logic signed [DATA_W-1:0] w_next_data;
        logic signed [DATA_W-1:0] w_next_prio;

        assign w_occ[g] = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_head
            assign w_prev_gt   = 1'b0;
            assign w_prev_data = '0;
            assign w_prev_prio = '0;
        end else begin : g_body
            assign w_prev_gt   = w_gt[g-1];
            assign w_prev_data = w_data[g-1];
            assign w_prev_prio = w_prio[g-1];
        end

        // the tail becomes empty on a remove, so its new contents never matter
        if (g == DEPTH - 1) begin : g_tail
            assign w_next_data = '0;
            assign w_next_prio = '0;
        end else begin : g_inner
            assign w_next_data = w_data[g+1];
            assign w_next_prio = w_prio[g+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_occupied  (w_occ[g]),
            .i_new_data  (i_req.item_data),
            .i_new_prio  (i_req.item_priority),
            .i_prev_gt   (w_prev_gt),
            .i_prev_data (w_prev_data),
            .i_prev_prio (w_prev_prio),
            .i_next_data (w_next_data),
            .i_next_prio (w_next_prio),
            .o_gt        (w_gt[g]),
            .o_data      (w_data[g]),
            .o_prio      (w_prio[g])
        );
    end

    // count, status and result capture
    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_status    = r_status;
        n_out_data  = r_out_data;
        n_out_prio  = r_out_prio;
        if (w_accept) begin
            n_out_valid = 1'b1;
            n_status    = ST_OK;
            n_out_data  = '0;
            n_out_prio  = '0;
            if (i_req.cmd == CMD_INSERT) begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end else begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    // head entry leaves the chain this cycle
                    n_out_data = w_data[0];
                    n_out_prio = w_prio[0];
                    n_count    = r_count - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload of the result register, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status   <= n_status;
            r_out_data <= n_out_data;
            r_out_prio <= n_out_prio;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.out_data     = r_out_data;
    assign o_rsp.out_priority = r_out_prio;
    // occupancy after the operation is the count at the result's own cycle
    assign o_rsp.occupancy    = OCC_W'(r_count);
endmodule

/* rtl/core/spq_cell.sv */
// one slot of the sorted chain with its local compare and shift mux
module spq_cell
    import spq_pkg::*;
(
    input  logic                      i_clk,
    input  t_cell_ctl                 i_ctl,
    input  logic                      i_occupied,
    input  logic signed [DATA_W-1:0]  i_new_data,
    input  logic signed [DATA_W-1:0]  i_new_prio,
    input  logic                      i_prev_gt,
    input  logic signed [DATA_W-1:0]  i_prev_data,
    input  logic signed [DATA_W-1:0]  i_prev_prio,
    input  logic signed [DATA_W-1:0]  i_next_data,
    input  logic signed [DATA_W-1:0]  i_next_prio,
    output logic                      o_gt,
    output logic signed [DATA_W-1:0]  o_data,
    output logic signed [DATA_W-1:0]  o_prio
);
    logic signed [DATA_W-1:0] r_data, n_data;
    logic signed [DATA_W-1:0] r_prio, n_prio;

    // new entry belongs at or ahead of this slot
    assign o_gt = !i_occupied || (i_new_prio > r_prio);

    always_comb begin
        n_data = r_data;
        n_prio = r_prio;
        if (i_ctl.ins && o_gt) begin
            if (i_prev_gt) begin
                n_data = i_prev_data;
                n_prio = i_prev_prio;
            end else begin
                n_data = i_new_data;
                n_prio = i_new_prio;
            end
        end else if (i_ctl.rem) begin
            n_data = i_next_data;
            n_prio = i_next_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_prio <= n_prio;
    end

    assign o_data = r_data;
    assign o_prio = r_prio;
endmodule

/* rtl/core/spq_checker.sv */
// port-level checks of the sorted priority queue and their bind
module spq_checker
    import spq_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  t_status                   i_status,
    input  logic signed [DATA_W-1:0]  i_out_data,
    input  logic signed [DATA_W-1:0]  i_out_priority,
    input  logic [OCC_W-1:0]          i_occupancy
);
    // a waiting result holds until transferred
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_out_data) && $stable(i_out_priority))
        else $error("result changed while stalled");

    // refused operations hand out no entry
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_OK) |-> (i_out_data == '0) && (i_out_priority == '0))
        else $error("refused operation carries an entry");

    // empty status only with an empty queue, full only with a full one
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_EMPTY) |-> (i_occupancy == '0))
        else $error("empty status with entries held");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_FULL) |-> (i_occupancy == OCC_W'(DEPTH)))
        else $error("full status below capacity");
endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_status       (o_rsp.status),
    .i_out_data     (o_rsp.out_data),
    .i_out_priority (o_rsp.out_priority),
    .i_occupancy    (o_rsp.occupancy)
);
